>>> hdl/wct_pkg.sv
// ----------------------------------------------------------------------------
// wct_pkg
// Shared types and constants for the weighted choice table.
// ----------------------------------------------------------------------------
package wct_pkg;

  localparam int TABLE_DEPTH_DFLT = 32;

  // operation codes carried on the kind field
  typedef enum logic [2:0] {
    KIND_APPEND  = 3'd0,
    KIND_ERASE   = 3'd1,
    KIND_FIND    = 3'd2,
    KIND_DRAW    = 3'd3,
    KIND_RESCALE = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_NONE      = 2'd3
  } status_t;

  localparam logic [36:0] SUM_MAX   = 37'h1F_FFFF_FFFF;
  localparam int          PROD_W    = 69;
  localparam logic [40:0] DELTA_CAP = 41'h100_0000_0000;

  typedef struct packed {
    logic [31:0]        weight;
    logic signed [31:0] spread;
    logic [31:0]        key;
  } entry_t;

endpackage

>>> hdl/wct_div.sv
// ----------------------------------------------------------------------------
// wct_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module wct_div #(
  parameter int DVD_W = wct_pkg::PROD_W,
  parameter int DVS_W = 37
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W:0]   rem_r;
  logic [DVD_W-1:0] dvd_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem_r[DVS_W-1:0], dvd_r[DVD_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
        rem_r  <= '0;
        dvd_r  <= dividend;
        dvs_r  <= divisor;
        quo_r  <= '0;
      end else if (busy_r) begin
        rem_r <= fits ? rem_sh - {1'b0, dvs_r} : rem_sh;
        quo_r <= {quo_r[DVD_W-2:0], fits};
        dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> hdl/weighted_choice_table.sv
// ----------------------------------------------------------------------------
// weighted_choice_table
// Weighted table with append, erase, key find, weighted draw and rescale.
// ----------------------------------------------------------------------------
// One item at a time; each entry visit is a read plus an evaluate cycle on the
// single-port entry memory. Append/find/draw walk the entries from index 0,
// erase from idx to the end; rescale walks them twice, the second pass waiting
// on the bit-serial divider per entry. Unknown kinds go straight to the result.
// Reset (synchronous, active low) clears count, total, target and handshake
// state; entry memory is left as is and never read before being written.
module weighted_choice_table #(
  parameter int TABLE_DEPTH = wct_pkg::TABLE_DEPTH_DFLT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_kind,
  input  logic [31:0]        in_entry_width,
  input  logic signed [31:0] in_entry_spread,
  input  logic [31:0]        in_entry_key,
  input  logic [4:0]         in_entry_index,
  input  logic [31:0]        in_random_fraction,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic               out_duplicate_key,
  output logic [4:0]         out_chosen_index,
  output logic [36:0]        out_total_width,
  output logic [5:0]         out_entry_count,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_target_width
);

  localparam int IW  = $clog2(TABLE_DEPTH);
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int SSW = 33 + IW;
  localparam int PW  = wct_pkg::PROD_W;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_EV, S_APP_WR, S_ER_RD, S_ER_WR, S_DRAW_MUL, S_DRAW_ADD,
    S_RS_CHK, S_RS_MUL, S_RS_ADD, S_RS_DIV, S_RS_WB, S_FIN
  } state_t;

  state_t                 state_r;
  wct_pkg::kind_t         kind_r;
  logic [31:0]            width_r;
  logic signed [31:0]     spread_r;
  logic [31:0]            key_r;
  logic [31:0]            frac_r;
  logic [31:0]            target_r;
  logic [CW-1:0]          cnt_r;
  logic [CW-1:0]          ptr_r;
  logic [36:0]            sum_r;
  logic [36:0]            acc_r;
  logic [36:0]            rem_r;
  logic signed [SSW-1:0]  ssum_r;
  logic [36:0]            gap_mag_r;
  logic                   gap_neg_r;
  logic                   phase_r;
  logic [63:0]            p0_r;
  logic [36:0]            p1_r;
  wct_pkg::entry_t        cur_r;
  wct_pkg::status_t       status_r;
  logic                   dup_r;
  logic [CW-1:0]          chosen_r;
  logic                   out_valid_r;
  logic [1:0]             o_status_r;
  logic                   o_dup_r;
  logic [4:0]             o_chosen_r;
  logic [36:0]            o_total_r;
  logic [5:0]             o_count_r;

  wct_pkg::entry_t        mem [TABLE_DEPTH];
  wct_pkg::entry_t        rd_q;
  wct_pkg::entry_t        mem_wd;
  logic                   mem_we, mem_re;
  logic [IW-1:0]          mem_wa, mem_ra;

  logic [CW-1:0]          ptr_inc;
  logic                   last;
  logic [31:0]            sp_mag;
  logic [PW-1:0]          quo;
  logic                   div_done;
  logic [40:0]            qcap;
  logic signed [42:0]     w_ext, q_ext, w_new;
  logic [31:0]            w_sat;
  logic [37:0]            acc_add;
  logic [36:0]            acc_sat;
  logic [37:0]            app_add;
  logic                   in_xfer;

  assign in_xfer   = in_valid && !in_stall;
  assign in_stall  = state_r != S_IDLE;
  assign cfg_ready = 1'b1;
  assign ptr_inc   = ptr_r + 1'b1;
  assign last      = ptr_inc == cnt_r;
  assign sp_mag    = cur_r.spread[31] ? (~cur_r.spread + 32'd1) : cur_r.spread;

  assign qcap    = (quo > PW'(wct_pkg::DELTA_CAP)) ? wct_pkg::DELTA_CAP : quo[40:0];
  assign w_ext   = $signed({11'b0, cur_r.weight});
  assign q_ext   = $signed({2'b0, qcap});
  assign w_new   = (cur_r.spread[31] != gap_neg_r) ? w_ext - q_ext : w_ext + q_ext;
  assign w_sat   = w_new[42] ? 32'd0 :
                   (w_new > 43'sh0_FFFF_FFFF) ? 32'hFFFF_FFFF : w_new[31:0];
  assign acc_add = {1'b0, acc_r} + {6'b0, w_sat};
  assign acc_sat = acc_add[37] ? wct_pkg::SUM_MAX : acc_add[36:0];
  assign app_add = {1'b0, sum_r} + {6'b0, width_r};

  wct_div #(.DVD_W(PW), .DVS_W(SSW - 1)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_RS_ADD),
    .dividend ({5'b0, p0_r} + {p1_r, 32'b0}),
    .divisor  (ssum_r[SSW-2:0]),
    .done     (div_done),
    .quotient (quo)
  );

  // memory port control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = ptr_r[IW-1:0];
    mem_wd = rd_q;
    mem_re = 1'b0;
    mem_ra = ptr_r[IW-1:0];
    case (state_r)
      S_RD: mem_re = 1'b1;
      S_ER_RD: begin
        mem_re = ptr_inc < cnt_r;
        mem_ra = ptr_inc[IW-1:0];
      end
      S_APP_WR: begin
        mem_we = cnt_r < CW'(TABLE_DEPTH);
        mem_wa = cnt_r[IW-1:0];
        mem_wd = '{weight: width_r, spread: spread_r, key: key_r};
      end
      S_ER_WR: mem_we = 1'b1;
      S_RS_WB: begin
        mem_we = 1'b1;
        mem_wd = '{weight: w_sat, spread: cur_r.spread, key: cur_r.key};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_q <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sum_r       <= '0;
      target_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) target_r <= cfg_target_width;
      if (out_valid_r && !out_stall && state_r != S_FIN) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            kind_r   <= wct_pkg::kind_t'(in_kind);
            width_r  <= in_entry_width;
            spread_r <= in_entry_spread;
            key_r    <= in_entry_key;
            frac_r   <= in_random_fraction;
            status_r <= wct_pkg::ST_OK;
            dup_r    <= 1'b0;
            chosen_r <= '0;
            ptr_r    <= '0;
            phase_r  <= 1'b0;
            ssum_r   <= '0;
            case (wct_pkg::kind_t'(in_kind))
              wct_pkg::KIND_APPEND: state_r <= (cnt_r == '0) ? S_APP_WR : S_RD;
              wct_pkg::KIND_ERASE: begin
                if (32'(in_entry_index) >= 32'(cnt_r)) begin
                  status_r <= wct_pkg::ST_BAD_INDEX;
                  state_r  <= S_FIN;
                end else begin
                  ptr_r   <= CW'(in_entry_index);
                  state_r <= S_RD;
                end
              end
              wct_pkg::KIND_FIND: begin
                status_r <= wct_pkg::ST_NONE;
                state_r  <= (cnt_r == '0) ? S_FIN : S_RD;
              end
              wct_pkg::KIND_DRAW: state_r <= S_DRAW_MUL;
              wct_pkg::KIND_RESCALE: begin
                if ({5'b0, target_r} == sum_r || cnt_r == '0) state_r <= S_FIN;
                else state_r <= S_RD;
              end
              default: state_r <= S_FIN;
            endcase
          end
        end
        S_RD: state_r <= S_EV;
        S_EV: begin
          case (kind_r)
            wct_pkg::KIND_APPEND: begin
              if (rd_q.key == key_r && width_r != 32'd0) dup_r <= 1'b1;
              ptr_r   <= ptr_inc;
              state_r <= last ? S_APP_WR : S_RD;
            end
            wct_pkg::KIND_ERASE: begin
              sum_r   <= (sum_r >= {5'b0, rd_q.weight}) ? sum_r - {5'b0, rd_q.weight} : '0;
              state_r <= S_ER_RD;
            end
            wct_pkg::KIND_FIND: begin
              if (rd_q.key == key_r) begin
                status_r <= wct_pkg::ST_OK;
                chosen_r <= ptr_r;
                state_r  <= S_FIN;
              end else begin
                ptr_r   <= ptr_inc;
                state_r <= last ? S_FIN : S_RD;
              end
            end
            wct_pkg::KIND_DRAW: begin
              if (rem_r < {5'b0, rd_q.weight}) begin
                chosen_r <= ptr_r;
                state_r  <= S_FIN;
              end else begin
                rem_r <= rem_r - {5'b0, rd_q.weight};
                ptr_r <= ptr_inc;
                if (last) begin
                  // no hit: a lone entry still answers index 0
                  status_r <= (cnt_r == CW'(1)) ? wct_pkg::ST_OK : wct_pkg::ST_NONE;
                  state_r  <= S_FIN;
                end else begin
                  state_r <= S_RD;
                end
              end
            end
            default: begin
              if (!phase_r) begin
                ssum_r  <= ssum_r + SSW'(rd_q.spread);
                ptr_r   <= ptr_inc;
                state_r <= last ? S_RS_CHK : S_RD;
              end else begin
                cur_r   <= rd_q;
                state_r <= S_RS_MUL;
              end
            end
          endcase
        end
        S_APP_WR: begin
          if (cnt_r < CW'(TABLE_DEPTH)) begin
            cnt_r <= cnt_r + 1'b1;
            sum_r <= app_add[37] ? wct_pkg::SUM_MAX : app_add[36:0];
          end else begin
            status_r <= wct_pkg::ST_FULL;
          end
          state_r <= S_FIN;
        end
        S_ER_RD: begin
          if (ptr_inc < cnt_r) begin
            state_r <= S_ER_WR;
          end else begin
            cnt_r   <= cnt_r - 1'b1;
            state_r <= S_FIN;
          end
        end
        S_ER_WR: begin
          ptr_r   <= ptr_inc;
          state_r <= S_ER_RD;
        end
        S_DRAW_MUL: begin
          p0_r    <= sum_r[31:0] * frac_r;
          p1_r    <= {32'b0, sum_r[36:32]} * {5'b0, frac_r};
          state_r <= S_DRAW_ADD;
        end
        S_DRAW_ADD: begin
          rem_r <= p1_r + {5'b0, p0_r[63:32]};
          if (cnt_r == '0) begin
            status_r <= wct_pkg::ST_NONE;
            state_r  <= S_FIN;
          end else begin
            state_r <= S_RD;
          end
        end
        S_RS_CHK: begin
          gap_neg_r <= sum_r > {5'b0, target_r};
          gap_mag_r <= (sum_r > {5'b0, target_r}) ? sum_r - {5'b0, target_r}
                                                   : {5'b0, target_r} - sum_r;
          ptr_r   <= '0;
          acc_r   <= '0;
          phase_r <= 1'b1;
          state_r <= (ssum_r[SSW-1] || ssum_r == '0) ? S_FIN : S_RD;
        end
        S_RS_MUL: begin
          p0_r    <= sp_mag * gap_mag_r[31:0];
          p1_r    <= {5'b0, sp_mag} * {32'b0, gap_mag_r[36:32]};
          state_r <= S_RS_ADD;
        end
        S_RS_ADD: state_r <= S_RS_DIV;
        S_RS_DIV: if (div_done) state_r <= S_RS_WB;
        S_RS_WB: begin
          acc_r <= acc_sat;
          ptr_r <= ptr_inc;
          if (last) begin
            sum_r   <= acc_sat;
            state_r <= S_FIN;
          end else begin
            state_r <= S_RD;
          end
        end
        S_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            o_status_r  <= status_r;
            o_dup_r     <= dup_r;
            o_chosen_r  <= (status_r == wct_pkg::ST_OK) ? 5'(chosen_r) : 5'd0;
            o_total_r   <= sum_r;
            o_count_r   <= 6'(cnt_r);
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = o_status_r;
  assign out_duplicate_key = o_dup_r;
  assign out_chosen_index  = o_chosen_r;
  assign out_total_width   = o_total_r;
  assign out_entry_count   = o_count_r;

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> in_stall)
    else $error("input taken while an item is in flight");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_RS_DIV)
    else $error("divider finished outside rescale");

  a_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> state_r != S_IDLE && state_r != S_FIN)
    else $error("table write outside an operation");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for weighted_choice_table: a directed table walks the
// empty, single-entry, duplicate-key, bad-index and unknown-kind cases, then
// random append/erase/find/draw/rescale and unknown-kind traffic runs under
// several rescale targets; results checked vs typed rows or in-bench model.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DEPTH = 32;
  localparam logic [2:0] KIND_SPARE = 3'd5;
  localparam int N_DIR = 25;
  localparam int N_PHASE = 5;
  localparam int PHASE_ITEMS = 285;

  typedef struct packed {
    wct_pkg::status_t status;
    logic        dup;
    logic [4:0]  chosen;
    logic [36:0] total;
    logic [5:0]  count;
  } result_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] width;
    logic [31:0] spread;
    logic [31:0] key;
    logic [4:0]  index;
    logic [31:0] frac;
    logic        typed;
    result_t     res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_kind = '0;
  logic [31:0] in_entry_width = '0;
  logic signed [31:0] in_entry_spread = '0;
  logic [31:0] in_entry_key = '0;
  logic [4:0] in_entry_index = '0;
  logic [31:0] in_random_fraction = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic out_duplicate_key;
  logic [4:0] out_chosen_index;
  logic [36:0] out_total_width;
  logic [5:0] out_entry_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_target_width = '0;

  weighted_choice_table uut (.*);

  always #6 clk = ~clk;

  // table model state
  logic [31:0]        tbl_weight [DEPTH];
  logic signed [31:0] tbl_spread [DEPTH];
  logic [31:0]        tbl_key    [DEPTH];
  int unsigned        tbl_count;
  logic [36:0]        tbl_total;
  logic [31:0]        tbl_target;

  result_t pending_results [$];
  int errors = 0;
  bit quiet = 0;
  bit hold_req = 0;
  bit fill_bias = 0;

  function automatic logic [36:0] sum_sat(logic [36:0] a, logic [36:0] b);
    logic [37:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[37] ? wct_pkg::SUM_MAX : s[36:0];
  endfunction

  function automatic void rescale_table();
    longint spread_sum;
    longint gap;
    logic [68:0] gap_mag, sp_mag, q;
    longint w;
    logic [36:0] s;
    bit gap_neg, sp_neg;
    spread_sum = 0;
    s = '0;
    if ({5'd0, tbl_target} == tbl_total) return;
    for (int i = 0; i < tbl_count; i++) spread_sum += longint'(tbl_spread[i]);
    if (spread_sum <= 0) return;
    gap = longint'({1'b0, tbl_target}) - longint'({27'd0, tbl_total});
    gap_neg = gap < 0;
    gap_mag = gap_neg ? 69'(-gap) : 69'(gap);
    for (int i = 0; i < tbl_count; i++) begin
      sp_neg = tbl_spread[i] < 0;
      sp_mag = sp_neg ? 69'(-longint'(tbl_spread[i])) : 69'(tbl_spread[i]);
      q = (sp_mag * gap_mag) / 69'(spread_sum);
      if (q > 69'(wct_pkg::DELTA_CAP)) q = 69'(wct_pkg::DELTA_CAP);
      w = longint'({32'd0, tbl_weight[i]});
      if (sp_neg != gap_neg) w -= longint'(q);
      else w += longint'(q);
      if (w < 0) w = 0;
      if (w > 64'hFFFF_FFFF) w = 64'hFFFF_FFFF;
      tbl_weight[i] = w[31:0];
      s = sum_sat(s, {5'd0, tbl_weight[i]});
    end
    tbl_total = s;
  endfunction

  function automatic result_t table_step(stim_row_t it);
    result_t r;
    logic [63:0] rem;
    bit found;
    r = '{wct_pkg::ST_OK, 1'b0, 5'd0, 37'd0, 6'd0};
    case (it.kind)
      wct_pkg::KIND_APPEND: begin
        for (int i = 0; i < tbl_count; i++)
          if (tbl_key[i] == it.key && it.width != 0) r.dup = 1'b1;
        if (tbl_count >= DEPTH) r.status = wct_pkg::ST_FULL;
        else begin
          tbl_weight[tbl_count] = it.width;
          tbl_spread[tbl_count] = it.spread;
          tbl_key[tbl_count] = it.key;
          tbl_count++;
          tbl_total = sum_sat(tbl_total, {5'd0, it.width});
        end
      end
      wct_pkg::KIND_ERASE: begin
        if (it.index >= tbl_count) r.status = wct_pkg::ST_BAD_INDEX;
        else begin
          tbl_total = (tbl_total >= {5'd0, tbl_weight[it.index]}) ?
                      tbl_total - {5'd0, tbl_weight[it.index]} : '0;
          for (int i = it.index; i + 1 < tbl_count; i++) begin
            tbl_weight[i] = tbl_weight[i+1];
            tbl_spread[i] = tbl_spread[i+1];
            tbl_key[i] = tbl_key[i+1];
          end
          tbl_count--;
        end
      end
      wct_pkg::KIND_FIND: begin
        r.status = wct_pkg::ST_NONE;
        for (int i = 0; i < tbl_count; i++)
          if (tbl_key[i] == it.key) begin
            r.status = wct_pkg::ST_OK;
            r.chosen = 5'(i);
            break;
          end
      end
      wct_pkg::KIND_DRAW: begin
        rem = {59'd0, tbl_total[36:32]} * {32'd0, it.frac}
            + (({32'd0, tbl_total[31:0]} * {32'd0, it.frac}) >> 32);
        found = 0;
        for (int i = 0; i < tbl_count; i++) begin
          if (rem < {32'd0, tbl_weight[i]}) begin
            found = 1;
            r.chosen = 5'(i);
            break;
          end
          rem -= {32'd0, tbl_weight[i]};
        end
        // no pick: a lone entry still answers entry 0
        if (!found) r.status = (tbl_count == 1) ? wct_pkg::ST_OK : wct_pkg::ST_NONE;
      end
      wct_pkg::KIND_RESCALE: rescale_table();
      default: ;
    endcase
    r.total = tbl_total;
    r.count = 6'(tbl_count);
    return r;
  endfunction

  stim_row_t dir_rows [N_DIR] = '{
    '{wct_pkg::KIND_DRAW,    32'h0, 32'h0, 32'h0, 5'd0, 32'h0, 1'b1,
      '{wct_pkg::ST_NONE, 1'b0, 5'd0, 37'h0, 6'd0}},
    '{wct_pkg::KIND_ERASE,   32'h0, 32'h0, 32'h0, 5'd0, 32'h0, 1'b1,
      '{wct_pkg::ST_BAD_INDEX, 1'b0, 5'd0, 37'h0, 6'd0}},
    '{wct_pkg::KIND_FIND,    32'h0, 32'h0, 32'h0, 5'd0, 32'h0, 1'b1,
      '{wct_pkg::ST_NONE, 1'b0, 5'd0, 37'h0, 6'd0}},
    '{wct_pkg::KIND_APPEND,  32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0, 5'd0, 32'h0, 1'b1,
      '{wct_pkg::ST_OK, 1'b0, 5'd0, 37'hFFFF_FFFF, 6'd1}},
    '{wct_pkg::KIND_DRAW,    32'h0, 32'h0, 32'h0, 5'd0, 32'hFFFF_FFFF, 1'b1,
      '{wct_pkg::ST_OK, 1'b0, 5'd0, 37'hFFFF_FFFF, 6'd1}},
    // zero weight: same key is not a duplicate
    '{wct_pkg::KIND_APPEND,  32'h0, 32'h8000_0000, 32'h0, 5'd0, 32'h0, 1'b1,
      '{wct_pkg::ST_OK, 1'b0, 5'd0, 37'hFFFF_FFFF, 6'd2}},
    '{wct_pkg::KIND_APPEND,  32'h1, 32'h1, 32'h0, 5'd0, 32'h0, 1'b0, '0},
    '{wct_pkg::KIND_APPEND,  32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_FFFF, 5'd0,
      32'h0, 1'b0, '0},
    '{wct_pkg::KIND_FIND,    32'h0, 32'h0, 32'hFFFF_FFFF, 5'd0, 32'h0, 1'b0, '0},
    '{wct_pkg::KIND_FIND,    32'h0, 32'h0, 32'h0001_2345, 5'd0, 32'h0, 1'b0, '0},
    '{wct_pkg::KIND_DRAW,    32'h0, 32'h0, 32'h0, 5'd0, 32'h0, 1'b0, '0},
    '{wct_pkg::KIND_DRAW,    32'h0, 32'h0, 32'h0, 5'd0, 32'h8000_0000, 1'b0, '0},
    '{wct_pkg::KIND_RESCALE, 32'h0, 32'h0, 32'h0, 5'd0, 32'h0, 1'b0, '0},
    '{wct_pkg::KIND_ERASE,   32'h0, 32'h0, 32'h0, 5'd31, 32'h0, 1'b0, '0},
    '{wct_pkg::KIND_ERASE,   32'h0, 32'h0, 32'h0, 5'd0, 32'h0, 1'b0, '0},
    '{wct_pkg::KIND_ERASE,   32'h0, 32'h0, 32'h0, 5'd2, 32'h0, 1'b0, '0},
    '{3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF, 1'b0, '0},
    '{wct_pkg::KIND_ERASE,   32'h0, 32'h0, 32'h0, 5'd0, 32'h0, 1'b0, '0},
    '{wct_pkg::KIND_ERASE,   32'h0, 32'h0, 32'h0, 5'd0, 32'h0, 1'b0, '0},
    '{wct_pkg::KIND_APPEND,  32'h0, 32'h0001_0000, 32'h5, 5'd0, 32'h0, 1'b0, '0},
    '{wct_pkg::KIND_APPEND,  32'h0, 32'h0002_0000, 32'h6, 5'd0, 32'h0, 1'b0, '0},
    // all-zero weights with two entries: nothing selected
    '{wct_pkg::KIND_DRAW,    32'h0, 32'h0, 32'h0, 5'd0, 32'h7FFF_FFFF, 1'b0, '0},
    '{wct_pkg::KIND_ERASE,   32'h0, 32'h0, 32'h0, 5'd0, 32'h0, 1'b0, '0},
    '{wct_pkg::KIND_ERASE,   32'h0, 32'h0, 32'h0, 5'd0, 32'h0, 1'b0, '0},
    '{wct_pkg::KIND_RESCALE, 32'h0, 32'h0, 32'h0, 5'd0, 32'h0, 1'b0, '0}
  };

  function automatic stim_row_t random_item();
    stim_row_t it;
    int pick;
    it = '0;
    pick = $urandom_range(0, 99);
    if (fill_bias && pick < 60) pick = 0;
    if (pick < 35) it.kind = wct_pkg::KIND_APPEND;
    else if (pick < 55) it.kind = wct_pkg::KIND_ERASE;
    else if (pick < 70) it.kind = wct_pkg::KIND_FIND;
    else if (pick < 90) it.kind = wct_pkg::KIND_DRAW;
    else if (pick < 96) it.kind = wct_pkg::KIND_RESCALE;
    else it.kind = KIND_SPARE + 3'($urandom_range(0, 2));
    case ($urandom_range(0, 5))
      0: it.width = '0;
      1: it.width = 32'hFFFF_FFFF;
      2, 3: it.width = $urandom_range(0, 32'h0010_0000);
      default: it.width = $urandom;
    endcase
    it.spread = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0040_0000);
    it.key = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0 || tbl_count == 0) it.index = 5'($urandom_range(0, 31));
    else it.index = 5'($urandom_range(0, tbl_count - 1));
    it.frac = $urandom;
    return it;
  endfunction

  task automatic send_item(stim_row_t it);
    result_t r;
    in_kind <= it.kind;
    in_entry_width <= it.width;
    in_entry_spread <= it.spread;
    in_entry_key <= it.key;
    in_entry_index <= it.index;
    in_random_fraction <= it.frac;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    r = table_step(it);
    pending_results.insert(pending_results.size(), it.typed ? it.res : r);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic drain_and_configure(logic [31:0] value);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (8) @(posedge clk);
    cfg_target_width <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tbl_target = value;
  endtask

  // result side: random stall bursts plus one long hold-off
  int stall_left = 0;
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req <= 1'b0;
      stall_left <= 400;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 15);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_status != e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_status); errors++;
        end
        if (out_duplicate_key != e.dup) begin
          $error("duplicate_key: expected %0d, got %0d", e.dup, out_duplicate_key); errors++;
        end
        if (out_chosen_index != e.chosen) begin
          $error("chosen_index: expected %0d, got %0d", e.chosen, out_chosen_index); errors++;
        end
        if (out_total_width != e.total) begin
          $error("total_width: expected %h, got %h", e.total, out_total_width); errors++;
        end
        if (out_entry_count != e.count) begin
          $error("entry_count: expected %0d, got %0d", e.count, out_entry_count); errors++;
        end
      end
    end
  end

  logic [31:0] phase_target [N_PHASE];

  initial begin
    int waited;
    tbl_count = 0;
    tbl_total = '0;
    tbl_target = '0;
    phase_target = '{32'hFFFF_FFFF, 32'h0, $urandom, 32'h0020_0000, $urandom};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < N_DIR; i++) send_item(dir_rows[i]);
    for (int p = 0; p < N_PHASE; p++) begin
      drain_and_configure(phase_target[p]);
      fill_bias = (p == 1);
      quiet = (p == N_PHASE - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 1 && n == 20) hold_req = 1'b1;
        send_item(random_item());
      end
    end
    in_valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      errors++;
    end
    repeat (20) @(posedge clk);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #250_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
